### src/blfq_pkg.sv
`timescale 1ns / 1ps
package blfq_pkg;

  localparam int MAX_FILTER_BITS = 1024;
  localparam int FS_W = 11;
  localparam int NH_W = 8;
  localparam int QDEPTH = 2;

  localparam logic [FS_W-1:0] FS_RESET = 11'd64;
  localparam logic [NH_W-1:0] NH_RESET = 8'd10;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] KEY_BYTES = 64'd8;

  localparam logic REG_FILTER_SIZE = 1'b0;
  localparam logic REG_NUM_HASHES = 1'b1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [FS_W-1:0] es;
    logic [NH_W-1:0] nh;
  } cfg_t;

  typedef struct packed {
    logic            op;
    logic [63:0]     s;
    logic [63:0]     b;
    logic [FS_W-1:0] ra;
    logic [FS_W-1:0] rb;
    logic [FS_W-1:0] w;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_MOD, F_PUSH} front_st_e;
  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_PROBE, B_FIN, B_DONE} back_st_e;

  function automatic logic [FS_W-1:0] mod_step(input logic [FS_W-1:0] r, input logic b,
                                               input logic [FS_W-1:0] es);
    logic [FS_W:0] t;
    t = {r, b};
    if (t >= {1'b0, es}) begin
      t = t - {1'b0, es};
    end
    return t[FS_W-1:0];
  endfunction

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

### src/blfq_fifo.sv
`timescale 1ns / 1ps
module blfq_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blfq_pkg::job_t  wr_data_i,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  output blfq_pkg::job_t  rd_data_o,
  output logic            rd_valid_o,
  input  logic            rd_ready_i
);
  localparam int PW = $clog2(blfq_pkg::QDEPTH);
  localparam int CW = $clog2(blfq_pkg::QDEPTH + 1);

  blfq_pkg::job_t slot_q [blfq_pkg::QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = (cnt_q != CW'(blfq_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = slot_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(blfq_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == PW'(blfq_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end
endmodule

### src/blfq_front.sv
`timescale 1ns / 1ps
module blfq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blfq_pkg::cfg_t  cfg_i,
  input  logic            en_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  logic [63:0]     key_i,
  output blfq_pkg::job_t  job_o,
  output logic            job_valid_o,
  input  logic            job_ready_i
);
  localparam int FS_W = blfq_pkg::FS_W;

  blfq_pkg::front_st_e st_q, st_d;
  logic            op_q;
  logic [63:0]     x_q, h1_q, h2_q, a_q, b_q, p_q, acc_q;
  logic [2:0]      ph_q;
  logic [1:0]      ms_q;
  logic [5:0]      cnt_q;
  logic [FS_W-1:0] ra_q, rb_q, rw_q;
  logic [63:0]     mc, res, h2f, fa;
  logic [31:0]     mx, my;
  logic [63:0]     prod;
  logic [FS_W:0]   wp1;
  logic            mul_done, mod_done;

  always_comb begin
    case (ph_q)
      3'd0:    mc = blfq_pkg::MM_C1;
      3'd1:    mc = blfq_pkg::MM_C2;
      3'd2:    mc = blfq_pkg::FMIX_M1;
      3'd3:    mc = blfq_pkg::FMIX_M2;
      3'd4:    mc = blfq_pkg::FMIX_M1;
      default: mc = blfq_pkg::FMIX_M2;
    endcase
  end

  always_comb begin
    case (ms_q)
      2'd1:    begin mx = x_q[31:0];  my = mc[63:32]; end
      2'd2:    begin mx = x_q[63:32]; my = mc[31:0];  end
      default: begin mx = x_q[31:0];  my = mc[31:0];  end
    endcase
  end

  assign prod = 64'(mx) * 64'(my);
  assign res = acc_q + {p_q[31:0], 32'h0};
  assign h2f = blfq_pkg::xs33(res);
  assign fa = h1_q + h2f;
  assign mul_done = (ms_q == 2'd3) && (ph_q == 3'd5);
  assign mod_done = (cnt_q == 6'd63);
  assign wp1 = {1'b0, rw_q} + (FS_W+1)'(1);

  always_comb begin
    st_d = st_q;
    case (st_q)
      blfq_pkg::F_IDLE: if (in_valid_i && in_ready_o) st_d = blfq_pkg::F_MUL;
      blfq_pkg::F_MUL:  if (mul_done) st_d = blfq_pkg::F_MOD;
      blfq_pkg::F_MOD:  if (mod_done) st_d = blfq_pkg::F_PUSH;
      blfq_pkg::F_PUSH: if (job_ready_i) st_d = blfq_pkg::F_IDLE;
      default:          st_d = blfq_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = en_i && (st_q == blfq_pkg::F_IDLE);
    job_valid_o = (st_q == blfq_pkg::F_PUSH);
    job_o.op = op_q;
    job_o.s = a_q;
    job_o.b = b_q;
    job_o.ra = ra_q;
    job_o.rb = rb_q;
    job_o.w = (wp1 == {1'b0, cfg_i.es}) ? '0 : wp1[FS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= blfq_pkg::F_IDLE;
      ph_q <= '0;
      ms_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        blfq_pkg::F_IDLE: begin
          ph_q <= '0;
          ms_q <= '0;
          cnt_q <= '0;
        end
        blfq_pkg::F_MUL: begin
          ms_q <= ms_q + 2'd1;
          if (ms_q == 2'd3) begin
            ph_q <= ph_q + 3'd1;
          end
        end
        blfq_pkg::F_MOD: cnt_q <= cnt_q + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      blfq_pkg::F_IDLE: begin
        op_q <= op_i;
        x_q <= key_i;
        ra_q <= '0;
        rb_q <= '0;
        rw_q <= '0;
      end
      blfq_pkg::F_MUL: begin
        case (ms_q)
          2'd0: p_q <= prod;
          2'd1: begin acc_q <= p_q; p_q <= prod; end
          2'd2: begin acc_q <= res; p_q <= prod; end
          default: begin
            case (ph_q)
              3'd0: x_q <= {res[32:0], res[63:33]};
              3'd1: begin
                h1_q <= (res ^ blfq_pkg::KEY_BYTES) + blfq_pkg::KEY_BYTES;
                h2_q <= (res ^ blfq_pkg::KEY_BYTES) + blfq_pkg::KEY_BYTES
                        + blfq_pkg::KEY_BYTES;
                x_q <= blfq_pkg::xs33((res ^ blfq_pkg::KEY_BYTES) + blfq_pkg::KEY_BYTES);
              end
              3'd2: x_q <= blfq_pkg::xs33(res);
              3'd3: begin
                h1_q <= blfq_pkg::xs33(res);
                x_q <= blfq_pkg::xs33(h2_q);
              end
              3'd4: x_q <= blfq_pkg::xs33(res);
              default: begin
                a_q <= fa;
                b_q <= h2f + fa;
              end
            endcase
          end
        endcase
      end
      blfq_pkg::F_MOD: begin
        ra_q <= blfq_pkg::mod_step(ra_q, a_q[~cnt_q], cfg_i.es);
        rb_q <= blfq_pkg::mod_step(rb_q, b_q[~cnt_q], cfg_i.es);
        rw_q <= blfq_pkg::mod_step(rw_q, 1'b1, cfg_i.es);
      end
      default: ;
    endcase
  end
endmodule

### src/blfq_back.sv
`timescale 1ns / 1ps
module blfq_back #(
  parameter int MAX_FILTER_BITS = blfq_pkg::MAX_FILTER_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blfq_pkg::cfg_t  cfg_i,
  input  blfq_pkg::job_t  job_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            possibly_present_o
);
  localparam int FS_W = blfq_pkg::FS_W;
  localparam int NH_W = blfq_pkg::NH_W;
  localparam int IDXW = $clog2(MAX_FILTER_BITS);

  blfq_pkg::back_st_e st_q, st_d;
  logic            mem [MAX_FILTER_BITS];
  logic [IDXW-1:0] ptr_q, maddr;
  logic            mem_we, mem_wd, rd_q;
  logic            op_q, all_q, chk_q, ov_q, res_q;
  logic [63:0]     s_q, b_q;
  logic [FS_W-1:0] r_q, rb_q, w_q, r_d;
  logic [NH_W-1:0] n_q;
  logic [64:0]     s_sum;
  logic [FS_W:0]   t1, t2, es_x;
  logic            miss, last, out_free;

  assign es_x = {1'b0, cfg_i.es};
  assign s_sum = {1'b0, s_q} + {1'b0, b_q};
  assign miss = chk_q && !rd_q;
  assign last = ({1'b0, n_q} + (NH_W+1)'(1)) == {1'b0, cfg_i.nh};
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    t1 = {1'b0, r_q} + {1'b0, rb_q};
    if (t1 >= es_x) begin
      t1 = t1 - es_x;
    end
    t2 = t1;
    if (s_sum[64]) begin
      if (t1 >= {1'b0, w_q}) begin
        t2 = t1 - {1'b0, w_q};
      end else begin
        t2 = t1 + es_x - {1'b0, w_q};
      end
    end
    r_d = t2[FS_W-1:0];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      blfq_pkg::B_CLEAR: if (ptr_q == IDXW'(MAX_FILTER_BITS - 1)) st_d = blfq_pkg::B_IDLE;
      blfq_pkg::B_IDLE: begin
        if (job_valid_i) begin
          st_d = (cfg_i.nh == '0) ? blfq_pkg::B_FIN : blfq_pkg::B_PROBE;
        end
      end
      blfq_pkg::B_PROBE: if (last) st_d = blfq_pkg::B_FIN;
      blfq_pkg::B_FIN:   st_d = blfq_pkg::B_DONE;
      blfq_pkg::B_DONE:  if (out_free) st_d = blfq_pkg::B_IDLE;
      default:           st_d = blfq_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (st_q == blfq_pkg::B_IDLE);
    clearing_o = (st_q == blfq_pkg::B_CLEAR);
    mem_we = clearing_o || ((st_q == blfq_pkg::B_PROBE) && (op_q == blfq_pkg::OP_ADD));
    mem_wd = !clearing_o;
    maddr = clearing_o ? ptr_q : IDXW'(r_q);
    out_valid_o = ov_q;
    possibly_present_o = res_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[maddr] <= mem_wd;
    end
    rd_q <= mem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= blfq_pkg::B_CLEAR;
      ptr_q <= '0;
      ov_q <= 1'b0;
      chk_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if ((st_q == blfq_pkg::B_DONE) && out_free) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        blfq_pkg::B_CLEAR: ptr_q <= ptr_q + IDXW'(1);
        blfq_pkg::B_IDLE:  chk_q <= 1'b0;
        blfq_pkg::B_PROBE: chk_q <= (op_q == blfq_pkg::OP_QUERY);
        blfq_pkg::B_FIN:   chk_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      blfq_pkg::B_IDLE: begin
        op_q <= job_i.op;
        s_q <= job_i.s;
        b_q <= job_i.b;
        r_q <= job_i.ra;
        rb_q <= job_i.rb;
        w_q <= job_i.w;
        n_q <= '0;
        all_q <= 1'b1;
      end
      blfq_pkg::B_PROBE: begin
        s_q <= s_sum[63:0];
        r_q <= r_d;
        n_q <= n_q + NH_W'(1);
        all_q <= all_q && !miss;
      end
      blfq_pkg::B_FIN: all_q <= (op_q == blfq_pkg::OP_QUERY) && all_q && !miss;
      blfq_pkg::B_DONE: if (out_free) res_q <= all_q;
      default: ;
    endcase
  end
endmodule

### src/bloom_filter_insert_query.sv
`timescale 1ns / 1ps
// channel   signals                                   beat
// in        in_valid_i / in_ready_o                   op_i, key_i
// out       out_valid_o / out_ready_i                 possibly_present_o
// cfg       psel penable pwrite paddr pwdata prdata   filter_size @0, num_hashes @4
// hashing runs on one shared 32x32 multiplier, followed by bit-serial residue
// reduction; the back end probes num_hashes bits of the single-port bit store.
// the two halves overlap through a 2-entry queue.
// after reset the bit store is cleared, and input is not taken meanwhile.
// either side may stall; a finished result waits in the output register.
module bloom_filter_insert_query #(
  parameter int MAX_FILTER_BITS = blfq_pkg::MAX_FILTER_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        possibly_present_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int FS_W = blfq_pkg::FS_W;
  localparam int NH_W = blfq_pkg::NH_W;

  logic [FS_W-1:0] fs_q;
  logic [NH_W-1:0] nh_q;
  blfq_pkg::cfg_t  cfg;
  blfq_pkg::job_t  fjob, bjob;
  logic            fvalid, fready, bvalid, bready, clearing;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == blfq_pkg::REG_NUM_HASHES) ? 32'(nh_q) : 32'(fs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= blfq_pkg::FS_RESET;
      nh_q <= blfq_pkg::NH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == blfq_pkg::REG_FILTER_SIZE) begin
        fs_q <= pwdata[FS_W-1:0];
      end else begin
        nh_q <= pwdata[NH_W-1:0];
      end
    end
  end

  always_comb begin
    cfg.nh = nh_q;
    if (fs_q == '0) begin
      cfg.es = FS_W'(1);
    end else if (32'(fs_q) > 32'(MAX_FILTER_BITS)) begin
      cfg.es = FS_W'(MAX_FILTER_BITS);
    end else begin
      cfg.es = fs_q;
    end
  end

  blfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .en_i        (!clearing),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .job_o       (fjob),
    .job_valid_o (fvalid),
    .job_ready_i (fready)
  );

  blfq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (fjob),
    .wr_valid_i (fvalid),
    .wr_ready_o (fready),
    .rd_data_o  (bjob),
    .rd_valid_o (bvalid),
    .rd_ready_i (bready)
  );

  blfq_back #(
    .MAX_FILTER_BITS (MAX_FILTER_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .job_i              (bjob),
    .job_valid_i        (bvalid),
    .job_ready_o        (bready),
    .clearing_o         (clearing),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .possibly_present_o (possibly_present_o)
  );
endmodule
